>>> rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared operation codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

endpackage

>>> rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Three register stages: products, sums of products, then saturation of the
// add/sub/multiply results and setup of the divide operands.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  cau_pkg::t_cmd         i_cmd,
    input  logic signed [W-1:0]   i_a_real,
    input  logic signed [W-1:0]   i_a_imag,
    input  logic signed [W-1:0]   i_b_real,
    input  logic signed [W-1:0]   i_b_imag,
    output cau_pkg::t_cmd         o_cmd,
    output logic [W-1:0]          o_res_r,
    output logic [W-1:0]          o_res_i,
    output logic                  o_ovf,
    output logic                  o_neg_r,
    output logic                  o_neg_i,
    output logic                  o_big_r,
    output logic                  o_big_i,
    output logic                  o_dz,
    output logic [2*W-1:0]        o_den,
    output logic [2*W-1:0]        o_rem_r,
    output logic [2*W-1:0]        o_rem_i,
    output logic [W-1:0]          o_low_r,
    output logic [W-1:0]          o_low_i
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int DW = 2 * W;
    localparam int NW = 2 * W + F;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // stage 1: products and add/sub
    cau_pkg::t_cmd        r1_cmd;
    logic signed [W:0]    r1_as_r, r1_as_i;
    logic signed [PW-1:0] r1_arbr, r1_aibi, r1_arbi, r1_aibr, r1_brbr, r1_bibi;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_cmd  <= i_cmd;
            if (i_cmd == cau_pkg::CMD_SUB) begin
                r1_as_r <= (W+1)'(i_a_real) - (W+1)'(i_b_real);
                r1_as_i <= (W+1)'(i_a_imag) - (W+1)'(i_b_imag);
            end else begin
                r1_as_r <= (W+1)'(i_a_real) + (W+1)'(i_b_real);
                r1_as_i <= (W+1)'(i_a_imag) + (W+1)'(i_b_imag);
            end
            r1_arbr <= PW'(i_a_real) * PW'(i_b_real);
            r1_aibi <= PW'(i_a_imag) * PW'(i_b_imag);
            r1_arbi <= PW'(i_a_real) * PW'(i_b_imag);
            r1_aibr <= PW'(i_a_imag) * PW'(i_b_real);
            r1_brbr <= PW'(i_b_real) * PW'(i_b_real);
            r1_bibi <= PW'(i_b_imag) * PW'(i_b_imag);
        end
    end

    // stage 2: sums of products, divisor magnitude squared
    cau_pkg::t_cmd        r2_cmd;
    logic signed [W:0]    r2_as_r, r2_as_i;
    logic signed [SW-1:0] r2_s_r, r2_s_i;
    logic [DW-1:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_cmd  <= r1_cmd;
            r2_as_r <= r1_as_r;
            r2_as_i <= r1_as_i;
            if (r1_cmd == cau_pkg::CMD_MUL) begin
                r2_s_r <= SW'(r1_arbr) - SW'(r1_aibi);
                r2_s_i <= SW'(r1_arbi) + SW'(r1_aibr);
            end else begin
                // a times conj(b)
                r2_s_r <= SW'(r1_arbr) + SW'(r1_aibi);
                r2_s_i <= SW'(r1_aibr) - SW'(r1_arbi);
            end
            r2_den  <= DW'($unsigned(r1_brbr)) + DW'($unsigned(r1_bibi));
        end
    end

    // stage 3: saturation, divide setup
    logic signed [SW-1:0] sh_r, sh_i;
    logic                 mo_r, mo_i, ao_r, ao_i;
    logic [W-1:0]         mv_r, mv_i, av_r, av_i;
    logic [SW-1:0]        mag_r, mag_i;
    logic [NW-1:0]        dvd_r, dvd_i, den_x;
    logic [W-1:0]         n_res_r, n_res_i;
    logic                 n_ovf;

    always_comb begin
        sh_r = r2_s_r >>> F;
        sh_i = r2_s_i >>> F;
        mo_r = !((&sh_r[SW-1:W-1]) || !(|sh_r[SW-1:W-1]));
        mo_i = !((&sh_i[SW-1:W-1]) || !(|sh_i[SW-1:W-1]));
        mv_r = mo_r ? (sh_r[SW-1] ? SAT_MIN : SAT_MAX) : sh_r[W-1:0];
        mv_i = mo_i ? (sh_i[SW-1] ? SAT_MIN : SAT_MAX) : sh_i[W-1:0];
        ao_r = r2_as_r[W] ^ r2_as_r[W-1];
        ao_i = r2_as_i[W] ^ r2_as_i[W-1];
        av_r = ao_r ? (r2_as_r[W] ? SAT_MIN : SAT_MAX) : r2_as_r[W-1:0];
        av_i = ao_i ? (r2_as_i[W] ? SAT_MIN : SAT_MAX) : r2_as_i[W-1:0];
        if (r2_cmd == cau_pkg::CMD_MUL) begin
            n_res_r = mv_r;
            n_res_i = mv_i;
            n_ovf   = mo_r | mo_i;
        end else begin
            n_res_r = av_r;
            n_res_i = av_i;
            n_ovf   = ao_r | ao_i;
        end
        mag_r = r2_s_r[SW-1] ? SW'(-r2_s_r) : SW'(r2_s_r);
        mag_i = r2_s_i[SW-1] ? SW'(-r2_s_i) : SW'(r2_s_i);
        dvd_r = NW'(mag_r[DW-1:0]) << F;
        dvd_i = NW'(mag_i[DW-1:0]) << F;
        den_x = NW'(r2_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_cmd   <= r2_cmd;
            o_res_r <= n_res_r;
            o_res_i <= n_res_i;
            o_ovf   <= n_ovf;
            o_neg_r <= r2_s_r[SW-1];
            o_neg_i <= r2_s_i[SW-1];
            // quotient would not fit W bits
            o_big_r <= (dvd_r >> W) >= den_x;
            o_big_i <= (dvd_i >> W) >= den_x;
            o_dz    <= (r2_cmd == cau_pkg::CMD_DIV) && (r2_den == '0);
            o_den   <= r2_den;
            o_rem_r <= DW'(dvd_r >> W);
            o_rem_i <= DW'(dvd_i >> W);
            o_low_r <= dvd_r[W-1:0];
            o_low_i <= dvd_i[W-1:0];
        end
    end

endmodule

>>> rtl/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division step for the real and imaginary lanes, registered.
// ----------------------------------------------------------------------------
module cau_div_step #(
    parameter int W  = 16,
    parameter int SB = 40
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SB-1:0]   i_side,
    input  logic [2*W-1:0]  i_den,
    input  logic [2*W-1:0]  i_rem_r,
    input  logic [2*W-1:0]  i_rem_i,
    input  logic [W-1:0]    i_quo_r,
    input  logic [W-1:0]    i_quo_i,
    input  logic [W-1:0]    i_low_r,
    input  logic [W-1:0]    i_low_i,
    output logic [SB-1:0]   o_side,
    output logic [2*W-1:0]  o_den,
    output logic [2*W-1:0]  o_rem_r,
    output logic [2*W-1:0]  o_rem_i,
    output logic [W-1:0]    o_quo_r,
    output logic [W-1:0]    o_quo_i,
    output logic [W-1:0]    o_low_r,
    output logic [W-1:0]    o_low_i
);

    localparam int DW = 2 * W;

    logic [DW:0] t_r, t_i, d_x;
    logic        ge_r, ge_i;

    always_comb begin
        d_x  = {1'b0, i_den};
        t_r  = {i_rem_r, i_low_r[W-1]};
        t_i  = {i_rem_i, i_low_i[W-1]};
        ge_r = t_r >= d_x;
        ge_i = t_i >= d_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side  <= i_side;
            o_den   <= i_den;
            o_rem_r <= ge_r ? DW'(t_r - d_x) : DW'(t_r);
            o_rem_i <= ge_i ? DW'(t_i - d_x) : DW'(t_i);
            o_quo_r <= {i_quo_r[W-2:0], ge_r};
            o_quo_i <= {i_quo_i[W-2:0], ge_i};
            o_low_r <= i_low_r << 1;
            o_low_i <= i_low_i << 1;
        end
    end

endmodule

>>> rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// usage:
//   input channel  : i_valid / o_stall, request = cmd plus operands a and b
//   output channel : o_valid / i_stall, request = result parts plus flags
//   a request is taken on a clock edge with valid high and stall low
//   every request goes through the same path, so results leave in order
//   stages: three front stages (products, sums, saturate/setup), one stage
//     per quotient bit of the restoring divider, and the output register
//   throughput: one request per cycle while the receiver does not stall
//   stall: the receiver stalling holds the output register; empty stages
//     behind it keep filling, and o_stall rises only once every stage holds
//     a request
//   reset: synchronous, active low; all stage valid bits clear, the data
//     registers keep whatever they held
//   results saturate to the DATA_WIDTH range with o_overflow; a divide by
//     zero gives zero parts with o_div_zero
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic                         o_overflow,
    output logic                         o_div_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int DW = 2 * W;
    // sideband: cmd, res_r, res_i, ovf, neg_r, neg_i, big_r, big_i, dz
    localparam int SB = 2 + 2 * W + 6;
    // front stages, one per quotient bit, output register
    localparam int NS = W + 4;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // ------------------------------------------------------------------
    // valid bits and per-stage enables; a stage moves when it is empty
    // or the stage after it moves
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // front stages
    // ------------------------------------------------------------------
    cau_pkg::t_cmd f_cmd;
    logic [W-1:0]  f_res_r, f_res_i;
    logic          f_ovf, f_neg_r, f_neg_i, f_big_r, f_big_i, f_dz;

    logic [SB-1:0] side [0:W];
    logic [DW-1:0] den  [0:W];
    logic [DW-1:0] rem_r[0:W];
    logic [DW-1:0] rem_i[0:W];
    logic [W-1:0]  quo_r[0:W];
    logic [W-1:0]  quo_i[0:W];
    logic [W-1:0]  low_r[0:W];
    logic [W-1:0]  low_i[0:W];

    cau_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (en[2:0]),
        .i_cmd    (cau_pkg::t_cmd'(i_cmd)),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_cmd    (f_cmd),
        .o_res_r  (f_res_r),
        .o_res_i  (f_res_i),
        .o_ovf    (f_ovf),
        .o_neg_r  (f_neg_r),
        .o_neg_i  (f_neg_i),
        .o_big_r  (f_big_r),
        .o_big_i  (f_big_i),
        .o_dz     (f_dz),
        .o_den    (den[0]),
        .o_rem_r  (rem_r[0]),
        .o_rem_i  (rem_i[0]),
        .o_low_r  (low_r[0]),
        .o_low_i  (low_i[0])
    );

    assign side[0]  = {f_cmd, f_res_r, f_res_i, f_ovf, f_neg_r, f_neg_i,
                       f_big_r, f_big_i, f_dz};
    assign quo_r[0] = '0;
    assign quo_i[0] = '0;

    // ------------------------------------------------------------------
    // divider: one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    for (genvar g = 0; g < W; g++) begin : g_div
        cau_div_step #(
            .W  (W),
            .SB (SB)
        ) u_step (
            .i_clk   (i_clk),
            .i_en    (en[3+g]),
            .i_side  (side[g]),
            .i_den   (den[g]),
            .i_rem_r (rem_r[g]),
            .i_rem_i (rem_i[g]),
            .i_quo_r (quo_r[g]),
            .i_quo_i (quo_i[g]),
            .i_low_r (low_r[g]),
            .i_low_i (low_i[g]),
            .o_side  (side[g+1]),
            .o_den   (den[g+1]),
            .o_rem_r (rem_r[g+1]),
            .o_rem_i (rem_i[g+1]),
            .o_quo_r (quo_r[g+1]),
            .o_quo_i (quo_i[g+1]),
            .o_low_r (low_r[g+1]),
            .o_low_i (low_i[g+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: sign and saturate quotients, pick the result
    // ------------------------------------------------------------------
    cau_pkg::t_cmd l_cmd;
    logic [W-1:0]  l_res_r, l_res_i, q_r, q_i;
    logic          l_ovf, l_neg_r, l_neg_i, l_big_r, l_big_i, l_dz;
    logic          qo_r, qo_i;
    logic [W-1:0]  qv_r, qv_i;
    logic [W-1:0]  n_res_r, n_res_i;
    logic          n_ovf, n_dz;

    always_comb begin
        {l_cmd, l_res_r, l_res_i, l_ovf, l_neg_r, l_neg_i, l_big_r, l_big_i, l_dz}
            = side[W];
        q_r = quo_r[W];
        q_i = quo_i[W];
        // a negative part may reach one step further than a positive one
        if (l_neg_r) begin
            qo_r = l_big_r || (q_r[W-1] && (|q_r[W-2:0]));
            qv_r = qo_r ? SAT_MIN : W'(-q_r);
        end else begin
            qo_r = l_big_r || q_r[W-1];
            qv_r = qo_r ? SAT_MAX : q_r;
        end
        if (l_neg_i) begin
            qo_i = l_big_i || (q_i[W-1] && (|q_i[W-2:0]));
            qv_i = qo_i ? SAT_MIN : W'(-q_i);
        end else begin
            qo_i = l_big_i || q_i[W-1];
            qv_i = qo_i ? SAT_MAX : q_i;
        end
        n_dz = 1'b0;
        if (l_cmd == cau_pkg::CMD_DIV) begin
            if (l_dz) begin
                n_res_r = '0;
                n_res_i = '0;
                n_ovf   = 1'b0;
                n_dz    = 1'b1;
            end else begin
                n_res_r = qv_r;
                n_res_i = qv_i;
                n_ovf   = qo_r | qo_i;
            end
        end else begin
            n_res_r = l_res_r;
            n_res_i = l_res_i;
            n_ovf   = l_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            o_res_real <= n_res_r;
            o_res_imag <= n_res_i;
            o_overflow <= n_ovf;
            o_div_zero <= n_dz;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // input side only backs up when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // divide by zero gives clean zero parts
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_res_real == '0 && o_res_imag == '0
                                     && !o_overflow))
        else $error("divide by zero with nonzero result");

    // overflow only comes with a part at a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_res_real == SAT_MAX || o_res_real == SAT_MIN
                                     || o_res_imag == SAT_MAX
                                     || o_res_imag == SAT_MIN))
        else $error("overflow flag without a saturated part");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
